[design/cbs_pkg.sv]
// shared widths, constants and types for the cubic b-spline point evaluator
package cbs_pkg;

   // field formats
   localparam int COORD_BITS  = 32;
   localparam int U_FRAC_BITS = 16;
   localparam int AXIS_W      = 2;
   localparam int U_W         = U_FRAC_BITS + 1;

   // u = 1.0 in Q1.F
   localparam logic [U_W-1:0] U_ONE = U_W'(1) << U_FRAC_BITS;

   // powers of u
   localparam int P2_W = 2 * U_FRAC_BITS + 1;
   localparam int P3_W = 3 * U_FRAC_BITS + 1;

   // basis weights are exact integers in units of 1/(6*2^(3F)), each at most 4*2^(3F)
   localparam int WEIGHT_W = 3 * U_FRAC_BITS + 3;
   localparam int W_LO_W   = WEIGHT_W / 2;
   localparam int W_HI_W   = WEIGHT_W - W_LO_W;

   // partial products of weight halves times a signed coordinate
   localparam int LO_PROD_W = W_LO_W + 1 + COORD_BITS;
   localparam int HI_PROD_W = W_HI_W + 1 + COORD_BITS;
   localparam int LO_SUM_W  = LO_PROD_W + 2;
   localparam int HI_SUM_W  = HI_PROD_W + 2;
   localparam int SUM_W     = WEIGHT_W + COORD_BITS + 4;

   // floor divide by 6: sum is shifted by 3F+1 and biased by 3*2^(C-1) so that
   // the dividend of the final divide by 3 is non-negative
   localparam int DIV_N_W   = COORD_BITS + 2;
   localparam int DIV_DROP  = 3 * U_FRAC_BITS + 1;
   localparam logic [SUM_W-1:0] DIV_OFFSET = SUM_W'(3) << (COORD_BITS + 3 * U_FRAC_BITS);

   // reciprocal of 3: ceil(2^k/3) with k = C+3 is exact for dividends below 2^(C+2)
   localparam int DIV_SHIFT = COORD_BITS + 3;
   localparam int RECIP_W   = COORD_BITS + 2;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << DIV_SHIFT) / 64'd3 + 64'd1);
   localparam int R_LO_W    = RECIP_W / 2;
   localparam int R_HI_W    = RECIP_W - R_LO_W;
   localparam int RPROD_W   = DIV_N_W + RECIP_W;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic [WEIGHT_W-1:0]          weight_type;
   typedef logic [DIV_N_W-1:0]           div_num_type;

   typedef struct packed {
      weight_type w0;
      weight_type w1;
      weight_type w2;
      weight_type w3;
   } weights_type;

   typedef struct packed {
      logic [AXIS_W-1:0] axis;
      coord_type         point_a;
      coord_type         point_b;
      coord_type         point_c;
      coord_type         point_d;
   } item_type;

endpackage

[design/cbs_weights.sv]
// three-stage pipeline that forms the four uniform cubic b-spline basis weights
module cbs_weights
   import cbs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [U_W-1:0]   param_u,
   output logic             out_valid,
   output weights_type      weights
);

   logic [2:0]        valid_ff;

   logic [U_W-1:0]    p_in;
   logic [U_W-1:0]    q_in;
   logic [U_W-1:0]    p1_ff;
   logic [P2_W-1:0]   p2_in;
   logic [P2_W-1:0]   q2_in;
   logic [P2_W-1:0]   p2_ff;
   logic [P2_W-1:0]   q2_ff;
   logic [U_W-1:0]    q1_ff;

   logic [U_W-1:0]    p1_s2_ff;
   logic [P2_W-1:0]   p2_s2_ff;
   logic [P3_W-1:0]   p3_in;
   logic [P3_W-1:0]   q3_in;
   logic [P3_W-1:0]   p3_ff;
   logic [P3_W-1:0]   q3_ff;

   weight_type        p3_ext;
   weight_type        p2_sh;
   weight_type        p1_sh;
   weight_type        one3;
   weights_type       weights_in;
   weights_type       weights_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   // stage 1: clamp u to one, squares
   always_comb begin
      p_in  = (param_u > U_ONE) ? U_ONE : param_u;
      q_in  = U_ONE - p_in;
      p2_in = P2_W'(p_in) * P2_W'(p_in);
      q2_in = P2_W'(q_in) * P2_W'(q_in);
   end

   always_ff @(posedge clock) begin
      p1_ff <= p_in;
      q1_ff <= q_in;
      p2_ff <= p2_in;
      q2_ff <= q2_in;
   end

   // stage 2: cubes
   always_comb begin
      p3_in = P3_W'(p2_ff) * P3_W'(p1_ff);
      q3_in = P3_W'(q2_ff) * P3_W'(q1_ff);
   end

   always_ff @(posedge clock) begin
      p3_ff    <= p3_in;
      q3_ff    <= q3_in;
      p2_s2_ff <= p2_ff;
      p1_s2_ff <= p1_ff;
   end

   // stage 3: weights, all non-negative so modular arithmetic is exact
   always_comb begin
      p3_ext = WEIGHT_W'(p3_ff);
      p2_sh  = WEIGHT_W'(p2_s2_ff) << U_FRAC_BITS;
      p1_sh  = WEIGHT_W'(p1_s2_ff) << (2 * U_FRAC_BITS);
      one3   = WEIGHT_W'(1) << (3 * U_FRAC_BITS);

      weights_in.w0 = WEIGHT_W'(q3_ff);
      weights_in.w3 = p3_ext;
      // 3u^3 - 6u^2 + 4
      weights_in.w1 = (p3_ext << 1) + p3_ext - (p2_sh << 2) - (p2_sh << 1) + (one3 << 2);
      // -3u^3 + 3u^2 + 3u + 1
      weights_in.w2 = (p2_sh << 1) + p2_sh + (p1_sh << 1) + p1_sh + one3
                      - (p3_ext << 1) - p3_ext;
   end

   always_ff @(posedge clock) begin
      weights_ff <= weights_in;
   end

   assign out_valid = valid_ff[2];
   assign weights   = weights_ff;

endmodule

[design/cbs_div6.sv]
// two-stage divide by 3 through a split reciprocal multiply, result re-centered
module cbs_div6
   import cbs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  div_num_type dividend,
   output logic        out_valid,
   output coord_type   quotient
);

   localparam logic [R_LO_W-1:0] RECIP_LO = RECIP[R_LO_W-1:0];
   localparam logic [R_HI_W-1:0] RECIP_HI = RECIP[RECIP_W-1:R_LO_W];

   logic [1:0]                  valid_ff;
   logic [DIV_N_W+R_LO_W-1:0]   prod_lo_in;
   logic [DIV_N_W+R_HI_W-1:0]   prod_hi_in;
   logic [DIV_N_W+R_LO_W-1:0]   prod_lo_ff;
   logic [DIV_N_W+R_HI_W-1:0]   prod_hi_ff;
   logic [RPROD_W-1:0]          prod_all;
   logic [COORD_BITS-1:0]       quo_biased;
   coord_type                   quotient_in;
   coord_type                   quotient_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[0], in_valid};
      end
   end

   always_comb begin
      prod_lo_in = (DIV_N_W+R_LO_W)'(dividend) * (DIV_N_W+R_LO_W)'(RECIP_LO);
      prod_hi_in = (DIV_N_W+R_HI_W)'(dividend) * (DIV_N_W+R_HI_W)'(RECIP_HI);
   end

   always_ff @(posedge clock) begin
      prod_lo_ff <= prod_lo_in;
      prod_hi_ff <= prod_hi_in;
   end

   // recombine halves, then remove the 2^(C-1) bias by flipping the top bit
   always_comb begin
      prod_all    = (RPROD_W'(prod_hi_ff) << R_LO_W) + RPROD_W'(prod_lo_ff);
      quo_biased  = prod_all[DIV_SHIFT +: COORD_BITS];
      quotient_in = {~quo_biased[COORD_BITS-1], quo_biased[COORD_BITS-2:0]};
   end

   always_ff @(posedge clock) begin
      quotient_ff <= quotient_in;
   end

   assign out_valid = valid_ff[1];
   assign quotient  = quotient_ff;

endmodule

[design/cubic_bspline_point_eval.sv]
// top level: pipelined uniform cubic b-spline evaluation of one axis per item
//
//   channel   handshake                 payload
//   -------   -----------------------   ----------------------------------------------
//   request   start, busy               req_axis, req_point_a..d, req_param_u
//   response  rsp_strobe (one cycle)    rsp_axis_out, rsp_curve_value
//
// one item per clock cycle; every transfer yields one response
// each response passes through the multiplier chain: squares, cubes, weights, partial
// products, partial sums, recombine, then the reciprocal multiply and re-centring of the divide by 3
// reset is synchronous and clears only the valid bits in flight
// busy is always low: the pipeline never stalls and the receiver cannot stall
module cubic_bspline_point_eval
   import cbs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  start,
   output logic                  busy,
   input  logic [AXIS_W-1:0]     req_axis,
   input  coord_type             req_point_a,
   input  coord_type             req_point_b,
   input  coord_type             req_point_c,
   input  coord_type             req_point_d,
   input  logic [U_W-1:0]        req_param_u,

   output logic                  rsp_strobe,
   output logic [AXIS_W-1:0]     rsp_axis_out,
   output coord_type             rsp_curve_value
);

   // request transfer
   logic                         req_fire;

   // weights pipeline and matching delay line for the item payload
   logic                         wt_valid;
   weights_type                  wt;
   item_type                     item_in;
   item_type                     item_ff [3];

   // stage 4: weight halves times coordinates
   logic                         s4_valid_ff;
   logic [AXIS_W-1:0]            s4_axis_ff;
   weight_type                   wt_arr [4];
   coord_type                    pt_arr [4];
   logic signed [LO_PROD_W-1:0]  lo_prod_in [4];
   logic signed [HI_PROD_W-1:0]  hi_prod_in [4];
   logic signed [LO_PROD_W-1:0]  lo_prod_ff [4];
   logic signed [HI_PROD_W-1:0]  hi_prod_ff [4];

   // stage 5: column sums
   logic                         s5_valid_ff;
   logic [AXIS_W-1:0]            s5_axis_ff;
   logic signed [LO_SUM_W-1:0]   lo_sum_in;
   logic signed [HI_SUM_W-1:0]   hi_sum_in;
   logic signed [LO_SUM_W-1:0]   lo_sum_ff;
   logic signed [HI_SUM_W-1:0]   hi_sum_ff;

   // stage 6: full sum, biased and scaled down to the divide-by-3 dividend
   logic                         s6_valid_ff;
   logic [AXIS_W-1:0]            s6_axis_ff;
   logic signed [SUM_W-1:0]      lo_ext;
   logic signed [SUM_W-1:0]      hi_ext;
   logic [SUM_W-1:0]             total;
   div_num_type                  num_in;
   div_num_type                  num_ff;

   // divide stages
   logic [AXIS_W-1:0]            div_axis_ff [2];
   logic                         div_valid;
   coord_type                    div_quo;

   assign busy     = 1'b0;
   assign req_fire = start && !busy;

   cbs_weights u_weights (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_fire),
      .param_u   (req_param_u),
      .out_valid (wt_valid),
      .weights   (wt)
   );

   // coordinates ride along with the weight computation
   always_comb begin
      item_in.axis    = req_axis;
      item_in.point_a = req_point_a;
      item_in.point_b = req_point_b;
      item_in.point_c = req_point_c;
      item_in.point_d = req_point_d;
   end

   always_ff @(posedge clock) begin
      item_ff[0] <= item_in;
      item_ff[1] <= item_ff[0];
      item_ff[2] <= item_ff[1];
   end

   // split each weight into halves so each multiply stays near 32 x 32
   always_comb begin
      wt_arr[0] = wt.w0;
      wt_arr[1] = wt.w1;
      wt_arr[2] = wt.w2;
      wt_arr[3] = wt.w3;
      pt_arr[0] = item_ff[2].point_a;
      pt_arr[1] = item_ff[2].point_b;
      pt_arr[2] = item_ff[2].point_c;
      pt_arr[3] = item_ff[2].point_d;
      for (int i = 0; i < 4; i++) begin
         lo_prod_in[i] = $signed({1'b0, wt_arr[i][W_LO_W-1:0]}) * pt_arr[i];
         hi_prod_in[i] = $signed({1'b0, wt_arr[i][WEIGHT_W-1:W_LO_W]}) * pt_arr[i];
      end
   end

   always_ff @(posedge clock) begin
      lo_prod_ff <= lo_prod_in;
      hi_prod_ff <= hi_prod_in;
      s4_axis_ff <= item_ff[2].axis;
   end

   // sums of the low and high halves kept apart to shorten the adders
   always_comb begin
      lo_sum_in = LO_SUM_W'(lo_prod_ff[0]) + LO_SUM_W'(lo_prod_ff[1])
                + LO_SUM_W'(lo_prod_ff[2]) + LO_SUM_W'(lo_prod_ff[3]);
      hi_sum_in = HI_SUM_W'(hi_prod_ff[0]) + HI_SUM_W'(hi_prod_ff[1])
                + HI_SUM_W'(hi_prod_ff[2]) + HI_SUM_W'(hi_prod_ff[3]);
   end

   always_ff @(posedge clock) begin
      lo_sum_ff  <= lo_sum_in;
      hi_sum_ff  <= hi_sum_in;
      s5_axis_ff <= s4_axis_ff;
   end

   // floor(sum / 2^(3F+1)) + 3*2^(C-1), always non-negative thanks to the bias
   always_comb begin
      lo_ext = lo_sum_ff;
      hi_ext = hi_sum_ff;
      total  = SUM_W'(hi_ext <<< W_LO_W) + SUM_W'(lo_ext) + DIV_OFFSET;
      num_in = total[DIV_DROP +: DIV_N_W];
   end

   always_ff @(posedge clock) begin
      num_ff     <= num_in;
      s6_axis_ff <= s5_axis_ff;
   end

   cbs_div6 u_div6 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s6_valid_ff),
      .dividend  (num_ff),
      .out_valid (div_valid),
      .quotient  (div_quo)
   );

   always_ff @(posedge clock) begin
      div_axis_ff[0] <= s6_axis_ff;
      div_axis_ff[1] <= div_axis_ff[0];
   end

   // valid bits through the top-level stages
   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= wt_valid;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
      end
   end

   assign rsp_strobe      = div_valid;
   assign rsp_axis_out    = div_axis_ff[1];
   assign rsp_curve_value = div_quo;

endmodule
